FILE: rtl/fre_pkg.sv
`default_nettype none
package fre_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned ExpBits   = 30;
  localparam int unsigned PropBits  = 16;
  localparam int unsigned TaylorN   = 12;
  localparam logic [31:0] Ln2Q30    = 32'd744261118;
  localparam logic [31:0] ExpOne    = 32'h4000_0000;

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_ATTACK_RATE = 1'b0,
    REG_TIME_STEP   = 1'b1
  } reg_idx_e;

  // control carried along a pipeline
  typedef struct packed {
    logic valid;
  } pipe_ctl_t;

  // saturate a 64-bit value to 32 bits
  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // reciprocal of a Taylor divisor, Q1.34 rounded up; gives the exact floor
  // quotient for every dividend below 2^30
  function automatic logic [34:0] recip_q34(input logic [3:0] n);
    case (n)
      4'd1:    recip_q34 = 35'h4_0000_0000;
      4'd2:    recip_q34 = 35'h2_0000_0000;
      4'd3:    recip_q34 = 35'h1_5555_5556;
      4'd4:    recip_q34 = 35'h1_0000_0000;
      4'd5:    recip_q34 = 35'h0_CCCC_CCCD;
      4'd6:    recip_q34 = 35'h0_AAAA_AAAB;
      4'd7:    recip_q34 = 35'h0_9249_2493;
      4'd8:    recip_q34 = 35'h0_8000_0000;
      4'd9:    recip_q34 = 35'h0_71C7_1C72;
      4'd10:   recip_q34 = 35'h0_6666_6667;
      4'd11:   recip_q34 = 35'h0_5D17_45D2;
      4'd12:   recip_q34 = 35'h0_5555_5556;
      default: recip_q34 = 35'h4_0000_0000;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fre_div.sv
`default_nettype none
// pipelined restoring divider, one quotient bit per stage, saturating at 32 bits
module fre_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [63:0] num_i,
  input  wire logic [31:0] den_i,
  output logic [31:0]      quo_o
);
  import fre_pkg::*;

  localparam int unsigned Steps = 32;

  logic [63:0] num_q [Steps+1];
  logic [31:0] den_q [Steps+1];
  logic [31:0] quo_q [Steps+1];
  logic        sat_q [Steps+1];
  logic [Steps:0] unused_rst;

  assign unused_rst = '0;

  // stage 0: detect overflow (quotient needs more than 32 bits) and zero divisor
  always_comb begin
    num_q[0] = num_i;
    den_q[0] = den_i;
    quo_q[0] = 32'd0;
    sat_q[0] = (den_i == 32'd0) || (num_i[63:32] >= den_i);
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [32:0] rem;
    logic [32:0] trial;
    logic [63:0] num_d;
    always_comb begin
      rem   = {num_q[s][63:32], num_q[s][31]};
      trial = rem - {1'b0, den_q[s]};
      num_d = {num_q[s][62:0], 1'b0};
      if (!trial[32]) begin
        num_d[63:32] = trial[31:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_d;
        den_q[s+1] <= den_q[s];
        quo_q[s+1] <= {quo_q[s][30:0], ~trial[32]};
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  assign quo_o = sat_q[Steps] ? 32'hFFFF_FFFF : quo_q[Steps];

  logic unused_ok;
  assign unused_ok = rst_ni | (|unused_rst) | (|ExpOne);

endmodule
`default_nettype wire

FILE: rtl/fre_omexp.sv
`default_nettype none
// pipelined 1 - exp(-x): x in Q16.16, result Q2.30
module fre_omexp (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] x_i,
  output logic [31:0]      y_o
);
  import fre_pkg::*;

  // range reduction: xq = x << 14 (46 bits), k = xq / ln2 via reciprocal multiply and correction
  logic [45:0] xq;
  assign xq = {x_i, 14'd0};

  // k fits in 6 bits when below 64; find k by comparing against k*ln2 multiples
  logic [5:0]  k_s1_q;
  logic [31:0] r_s1_q;
  logic        big_s1_q;

  // stage 1: coarse quotient via reciprocal multiply; stage 2 corrects it
  logic [45:0] k_est_q;
  logic [45:0] xq_q;

  logic [31:0] inv_ln2;
  assign inv_ln2 = 32'd6_051_101;  // floor(2^22/ln2)

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xq_q    <= xq;
      k_est_q <= 46'((64'(xq[45:22]) * 64'(inv_ln2)) >> 30);
    end
  end

  // stage 2: correct estimate (may be one or two low); an estimate of 31 or
  // more already means a full proportion, so only its low five bits are used
  logic [45:0] r0, r1, r2;
  logic [45:0] kl0;
  always_comb begin
    kl0 = {9'd0, 37'(k_est_q[4:0]) * 37'(Ln2Q30)};
    r0 = xq_q - kl0;
    r1 = r0 - 46'(Ln2Q30);
    r2 = r1 - 46'(Ln2Q30);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (r0 < 46'(Ln2Q30)) begin
        r_s1_q <= r0[31:0];
        big_s1_q <= k_est_q >= 46'd31;
        k_s1_q <= k_est_q[5:0];
      end else if (r1 < 46'(Ln2Q30)) begin
        r_s1_q <= r1[31:0];
        big_s1_q <= (k_est_q + 46'd1) >= 46'd31;
        k_s1_q <= 6'(k_est_q + 46'd1);
      end else begin
        r_s1_q <= r2[31:0];
        big_s1_q <= (k_est_q + 46'd2) >= 46'd31;
        k_s1_q <= 6'(k_est_q + 46'd2);
      end
    end
  end

  // Horner chain: per term, multiply stage then reciprocal stage
  logic [31:0] p_q   [TaylorN+1];
  logic [31:0] r_q   [TaylorN+1];
  logic [5:0]  k_q   [TaylorN+1];
  logic        big_q [TaylorN+1];
  logic [31:0] t_q   [TaylorN];
  logic [31:0] rr_q  [TaylorN];
  logic [5:0]  kk_q  [TaylorN];
  logic        bb_q  [TaylorN];

  always_comb begin
    p_q[0]   = ExpOne;
    r_q[0]   = r_s1_q;
    k_q[0]   = k_s1_q;
    big_q[0] = big_s1_q;
  end

  for (genvar i = 0; i < TaylorN; i++) begin : g_term
    localparam logic [3:0] N = 4'(TaylorN - i);
    logic [63:0] rp;
    logic [65:0] tq;
    logic [31:0] t;
    assign rp = 64'(r_q[i]) * 64'(p_q[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[i]  <= 32'(rp >> ExpBits);
        rr_q[i] <= r_q[i];
        kk_q[i] <= k_q[i];
        bb_q[i] <= big_q[i];
      end
    end
    assign tq = 66'(t_q[i]) * 66'(recip_q34(N));
    assign t  = 32'(tq >> 34);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[i+1]   <= (t >= ExpOne) ? 32'd0 : ExpOne - t;
        r_q[i+1]   <= rr_q[i];
        k_q[i+1]   <= kk_q[i];
        big_q[i+1] <= bb_q[i];
      end
    end
  end

  always_comb begin
    if (big_q[TaylorN]) begin
      y_o = ExpOne;
    end else begin
      y_o = ExpOne - (p_q[TaylorN] >> k_q[TaylorN]);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/functional_response_eval.sv
`default_nettype none
// Frazer-Gilbert functional response, one cell per word, Q16.16 in and out,
// proportions Q1.16. Fully pipelined: a word is accepted every cycle while the
// output is taken; the path runs through three effort stages, a 32-stage
// divider, a 26-stage exp unit, the supply multiply, a second rank of 32-stage
// dividers, a second rank of 26-stage exp units and the output register.
// A stall freezes the whole pipeline. Configure attack_rate at 0x0 and
// time_step at 0x4 only while idle.
module functional_response_eval (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] attacker_density_i,
  input  wire logic [31:0] host_density_i,
  input  wire logic [31:0] attack_demand_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      attack_supply_o,
  output logic [31:0]      hosts_hit_o,
  output logic [16:0]      host_hit_fraction_o,
  output logic [16:0]      attacker_success_fraction_o,
  output logic [16:0]      supply_demand_ratio_o
);
  import fre_pkg::*;

  localparam int unsigned DivLat = 32;
  localparam int unsigned ExpLat = 2 + 2 * TaylorN;
  // A: effort (3 stages) ; B: x divide ; C: exp ; D: supply mul (1) ;
  // E: two avg divides + ratio divide ; F: two exps ; G: hits mul (1)
  localparam int unsigned Lat = 3 + DivLat + ExpLat + 1 + DivLat + ExpLat + 1;

  // configuration registers
  logic [31:0] attack_rate_q, time_step_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_rate_q <= 32'd0;
      time_step_q   <= 32'(1) << FracBits;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ATTACK_RATE: attack_rate_q <= pwdata;
        REG_TIME_STEP:   time_step_q   <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[2])
      REG_ATTACK_RATE: prdata = attack_rate_q;
      REG_TIME_STEP:   prdata = time_step_q;
      default:         prdata = 32'd0;
    endcase
  end

  // pipeline enable: advance unless the output word is held
  logic en;
  logic [Lat-1:0] vld_q;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Lat-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // delay line for input fields
  localparam int unsigned DW = 96;
  function automatic logic [31:0] mulfix(input logic [31:0] a, input logic [31:0] b);
    mulfix = sat32((64'(a) * 64'(b)) >> FracBits);
  endfunction

  // stage A: effort
  logic [31:0] a1_e_q, a2_e_q;
  logic [DW-1:0] a1_d_q, a2_d_q, a3_d_q;
  logic [63:0] a3_num_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_e_q <= mulfix(attack_rate_q, attacker_density_i);
      a1_d_q <= {attacker_density_i, host_density_i, attack_demand_i};
      a2_e_q <= mulfix(a1_e_q, time_step_q);
      a2_d_q <= a1_d_q;
      a3_num_q <= 64'(a2_e_q) * 64'(a2_d_q[63:32]);
      a3_d_q <= a2_d_q;
    end
  end

  // stage B: x = effort*host/dem
  logic [31:0] x_w;
  fre_div u_div_x (.clk_i, .rst_ni, .en_i(en), .num_i(a3_num_q),
                   .den_i(a3_d_q[31:0]), .quo_o(x_w));
  logic [DW-1:0] b_d_q [DivLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_d_q[0] <= a3_d_q;
      for (int i = 1; i < DivLat; i++) b_d_q[i] <= b_d_q[i-1];
    end
  end

  // stage C: 1-exp(-x)
  logic [31:0] omx_w;
  fre_omexp u_exp_x (.clk_i, .en_i(en), .x_i(x_w), .y_o(omx_w));
  logic [DW-1:0] c_d_q [ExpLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_d_q[0] <= b_d_q[DivLat-1];
      for (int i = 1; i < ExpLat; i++) c_d_q[i] <= c_d_q[i-1];
    end
  end

  // stage D: supply
  logic [31:0] sup_q;
  logic [DW-1:0] d_d_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sup_q <= (c_d_q[ExpLat-1][31:0] == 32'd0) ? 32'd0 :
               32'((64'(c_d_q[ExpLat-1][31:0]) * 64'(omx_w)) >> ExpBits);
      d_d_q <= c_d_q[ExpLat-1];
    end
  end

  // stage E: averages and ratio
  logic [31:0] avh_w, ava_w, rat_w;
  fre_div u_div_h (.clk_i, .rst_ni, .en_i(en),
                   .num_i(64'(sup_q) << FracBits), .den_i(d_d_q[63:32]), .quo_o(avh_w));
  fre_div u_div_a (.clk_i, .rst_ni, .en_i(en),
                   .num_i(64'(sup_q) << FracBits), .den_i(d_d_q[95:64]), .quo_o(ava_w));
  fre_div u_div_r (.clk_i, .rst_ni, .en_i(en),
                   .num_i(64'(sup_q) << PropBits), .den_i(d_d_q[31:0]), .quo_o(rat_w));
  logic [DW-1:0] e_d_q [DivLat];
  logic [31:0]   e_s_q [DivLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_d_q[0] <= d_d_q;
      e_s_q[0] <= sup_q;
      for (int i = 1; i < DivLat; i++) begin
        e_d_q[i] <= e_d_q[i-1];
        e_s_q[i] <= e_s_q[i-1];
      end
    end
  end

  // stage F: proportions
  logic [31:0] ph_w, pa_w;
  fre_omexp u_exp_h (.clk_i, .en_i(en), .x_i(avh_w), .y_o(ph_w));
  fre_omexp u_exp_a (.clk_i, .en_i(en), .x_i(ava_w), .y_o(pa_w));
  logic [DW-1:0] f_d_q [ExpLat];
  logic [31:0]   f_s_q [ExpLat];
  logic [16:0]   f_r_q [ExpLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_d_q[0] <= e_d_q[DivLat-1];
      f_s_q[0] <= e_s_q[DivLat-1];
      f_r_q[0] <= (e_s_q[DivLat-1] == 32'd0 || e_d_q[DivLat-1][31:0] == 32'd0) ?
                  17'd0 : rat_w[16:0];
      for (int i = 1; i < ExpLat; i++) begin
        f_d_q[i] <= f_d_q[i-1];
        f_s_q[i] <= f_s_q[i-1];
        f_r_q[i] <= f_r_q[i-1];
      end
    end
  end

  // stage G: hits and output word
  logic [31:0] ph_m, pa_m;
  assign ph_m = (f_d_q[ExpLat-1][63:32] == 32'd0) ? 32'd0 : ph_w;
  assign pa_m = (f_d_q[ExpLat-1][95:64] == 32'd0) ? 32'd0 : pa_w;
  always_ff @(posedge clk_i) begin
    if (en) begin
      attack_supply_o             <= f_s_q[ExpLat-1];
      hosts_hit_o                 <= 32'((64'(ph_m) * 64'(f_d_q[ExpLat-1][63:32])) >> ExpBits);
      host_hit_fraction_o         <= ph_m[30:14];
      attacker_success_fraction_o <= pa_m[30:14];
      supply_demand_ratio_o       <= f_r_q[ExpLat-1];
    end
  end

  // checks
  a_prop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> host_hit_fraction_o <= 17'h10000) else $error("prop range");
  a_sup_le_dem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> supply_demand_ratio_o <= 17'h10000) else $error("ratio range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("output dropped");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

// one expected result word
typedef struct packed {
  logic [31:0] supply;
  logic [31:0] hits;
  logic [16:0] host_frac;
  logic [16:0] att_frac;
  logic [16:0] ratio;
} response_t;

// holds predicted responses and compares them with the block output
class response_board;
  response_t pending[$];
  int unsigned errors;
  int unsigned checked;

  function void note_word(response_t r);
    pending.push_back(r);
  endfunction

  function void check_word(response_t got);
    response_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected response %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.supply !== want.supply) begin
      $display("%0t: attack_supply expected %h actual %h", $time, want.supply, got.supply);
      errors++;
    end
    if (got.hits !== want.hits) begin
      $display("%0t: hosts_hit expected %h actual %h", $time, want.hits, got.hits);
      errors++;
    end
    if (got.host_frac !== want.host_frac) begin
      $display("%0t: host_hit_fraction expected %h actual %h", $time, want.host_frac,
               got.host_frac);
      errors++;
    end
    if (got.att_frac !== want.att_frac) begin
      $display("%0t: attacker_success_fraction expected %h actual %h", $time,
               want.att_frac, got.att_frac);
      errors++;
    end
    if (got.ratio !== want.ratio) begin
      $display("%0t: supply_demand_ratio expected %h actual %h", $time, want.ratio,
               got.ratio);
      errors++;
    end
  endfunction
endclass

module testbench;
  import fre_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] attacker_density_i = '0, host_density_i = '0, attack_demand_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] attack_supply_o, hosts_hit_o;
  logic [16:0] host_hit_fraction_o, attacker_success_fraction_o, supply_demand_ratio_o;

  functional_response_eval dut (.*);

  always #4 clk_i = ~clk_i;

  response_board board = new();
  logic [31:0] rate_q = 32'd0;
  logic [31:0] step_q = 32'h0001_0000;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_off_cycles = 0;
  int unsigned words_sent = 0;

  localparam logic [63:0] Sat = 64'hFFFF_FFFF;
  localparam logic [63:0] OneQ30 = 64'd1 << 30;

  function automatic logic [63:0] clip32(logic [63:0] v);
    return (v > Sat) ? Sat : v;
  endfunction

  function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
    return clip32((a * b) >> 16);
  endfunction

  // 1 - exp(-x), x in Q16.16, result Q2.30, by range reduction and Horner
  function automatic logic [63:0] one_less_exp(logic [63:0] x);
    logic [63:0] xq, k, r, p, t;
    xq = x << 14;
    k = xq / 64'd744261118;
    r = xq - k * 64'd744261118;
    p = OneQ30;
    if (k >= 31) return OneQ30;
    for (int n = 12; n >= 1; n--) begin
      t = ((r * p) >> 30) / n;
      p = (t >= OneQ30) ? 64'd0 : OneQ30 - t;
    end
    p = p >> k;
    return OneQ30 - p;
  endfunction

  function automatic response_t predict_response(logic [31:0] att, logic [31:0] host,
                                                 logic [31:0] dem);
    response_t   r;
    logic [63:0] effort, supply, ph, pa, hits, ratio, x;
    effort = fix_mul(fix_mul(rate_q, att), step_q);
    supply = 0; ph = 0; pa = 0; ratio = 0;
    if (dem != 0) begin
      x = clip32((effort * host) / dem);
      supply = (dem * one_less_exp(x)) >> 30;
    end
    if (host != 0) ph = one_less_exp(clip32((supply << 16) / host));
    if (att != 0) pa = one_less_exp(clip32((supply << 16) / att));
    hits = (ph * host) >> 30;
    if (supply != 0 && dem != 0) ratio = (supply << 16) / dem;
    r.supply = supply[31:0];
    r.hits = hits[31:0];
    r.host_frac = ph[30:14];
    r.att_frac = pa[30:14];
    r.ratio = ratio[16:0];
    return r;
  endfunction

  // register write: setup then access
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_ATTACK_RATE) rate_q = val; else step_q = val;
  endtask

  // offer one word, hold until taken
  task automatic send_word(logic [31:0] att, logic [31:0] host, logic [31:0] dem);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    attacker_density_i <= att; host_density_i <= host; attack_demand_i <= dem;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(predict_response(att, host, dem));
    words_sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom_range(3);
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return $urandom_range(32'h0004_0000);
      3: return $urandom_range(32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (260) @(posedge clk_i);
  endtask

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_word({attack_supply_o, hosts_hit_o, host_hit_fraction_o,
                          attacker_success_fraction_o, supply_demand_ratio_o});
      if (hold_off_cycles != 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [31:0] edge_vals [4];
    edge_vals = '{32'd0, 32'd1, 32'h0001_0000, 32'hFFFF_FFFF};
    send_idle_pct = 34; recv_idle_pct = 50;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset rate gives zero effort, then extremes
    send_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    wait_drained();
    write_reg(REG_ATTACK_RATE, 32'h0001_0000);
    write_reg(REG_TIME_STEP, 32'h0001_0000);
    for (int a = 0; a < 4; a++)
      for (int h = 0; h < 4; h++)
        if ((a + h) % 2 == 0 || h == 3)
          send_word(edge_vals[a], edge_vals[h], edge_vals[(a + 2 * h) % 4]);
    send_word(32'h0002_0000, 32'h0003_0000, 32'd0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    wait_drained();
    write_reg(REG_ATTACK_RATE, 32'hFFFF_FFFF);
    write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);

    // random phases, each with a fresh setting
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph == 2) begin send_idle_pct = 50; recv_idle_pct = 34; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(REG_ATTACK_RATE, (ph == 5) ? 32'd0 : rand_value());
      write_reg(REG_TIME_STEP, (ph == 1) ? 32'd0 : rand_value());
      if (ph == 4) hold_off_cycles = 600;
      for (int i = 0; i < 295; i++)
        send_word(rand_value(), rand_value(), rand_value());
    end
    wait_drained();

    $display("covered %0d words over nine register settings, zero and full-scale fields",
             words_sent);
    $display("%0d responses compared, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

`default_nettype wire

FILE: files.f
rtl/fre_pkg.sv
rtl/fre_div.sv
rtl/fre_omexp.sv
rtl/functional_response_eval.sv
verif/testbench.sv
